// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TSS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define TSS_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/tss_pkg.sv -----
// Types, codes and constants of the turntable step sequencer.
package tss_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CMP_W      = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam logic [TIMER_BITS-1:0] TIMER_TOP = {TIMER_BITS{1'b1}};

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_STOP   = 3'd0,
        PH_SETTLE = 3'd1,
        PH_PULSE  = 3'd2,
        PH_MOVE   = 3'd3,
        PH_ERR    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        RES_NONE    = 2'd0,
        RES_DONE    = 2'd1,
        RES_CANCEL  = 2'd2,
        RES_TIMEOUT = 2'd3
    } result_t;

    // Register indexes, byte address is 4 * index
    localparam logic [2:0] REG_SETTLE    = 3'd0;
    localparam logic [2:0] REG_PULSE     = 3'd1;
    localparam logic [2:0] REG_TIMEOUT   = 3'd2;
    localparam logic [2:0] REG_PWM       = 3'd3;
    localparam logic [2:0] REG_EXT       = 3'd4;
    localparam logic [2:0] REG_POLARITY  = 3'd5;
    localparam logic [2:0] REG_OUTLEVELS = 3'd6;
    localparam logic [2:0] REG_SENSLOW   = 3'd7;

    typedef struct packed {
        logic [15:0] settle_ticks;
        logic [15:0] pulse_ticks;
        logic [15:0] timeout_ticks;
        logic [7:0]  pwm_speed;
        logic        counter_external;
        logic        polarity_inverted;
        logic [1:0]  output_levels;
        logic [1:0]  sensor_active_low;
    } cfg_t;

    typedef struct packed {
        kind_t kind;
        logic  direction;
        logic  lock_pin;
        logic  counter_pin;
    } item_t;

    typedef struct packed {
        phase_t                phase;
        logic [TIMER_BITS-1:0] elapsed;
        logic                  movement_seen;
        result_t               pending_result;
        logic                  turn_direction;
        logic                  motor_on;
        logic                  unlock_on;
        logic                  lamp_on;
        logic                  prev_lock;
        logic                  prev_counter;
        logic                  primed;
        logic                  lock_event;
        logic                  counter_event;
    } state_t;

    typedef struct packed {
        logic [7:0] motor_duty;
        logic       direction_relay;
        logic       unlock_relay;
        logic       polarity_relay;
        logic       arrived_lamp;
        logic [2:0] phase_code;
        logic       busy_res;
        logic       accepted;
        logic [1:0] step_result;
        logic       lock_edge_seen;
    } res_t;

endpackage

// ----- rtl/tss_regs.sv -----
// APB configuration registers of the turntable step sequencer.
module tss_regs import tss_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_ticks      <= 16'd50;
            cfg_reg.pulse_ticks       <= 16'd200;
            cfg_reg.timeout_ticks     <= 16'd20000;
            cfg_reg.pwm_speed         <= 8'd255;
            cfg_reg.counter_external  <= 1'b0;
            cfg_reg.polarity_inverted <= 1'b0;
            cfg_reg.output_levels     <= 2'd3;
            cfg_reg.sensor_active_low <= 2'd3;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SETTLE:    cfg_reg.settle_ticks      <= pwdata[15:0];
                REG_PULSE:     cfg_reg.pulse_ticks       <= pwdata[15:0];
                REG_TIMEOUT:   cfg_reg.timeout_ticks     <= pwdata[15:0];
                REG_PWM:       cfg_reg.pwm_speed         <= pwdata[7:0];
                REG_EXT:       cfg_reg.counter_external  <= pwdata[0];
                REG_POLARITY:  cfg_reg.polarity_inverted <= pwdata[0];
                REG_OUTLEVELS: cfg_reg.output_levels     <= pwdata[1:0];
                REG_SENSLOW:   cfg_reg.sensor_active_low <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SETTLE:    prdata = {16'd0, cfg_reg.settle_ticks};
            REG_PULSE:     prdata = {16'd0, cfg_reg.pulse_ticks};
            REG_TIMEOUT:   prdata = {16'd0, cfg_reg.timeout_ticks};
            REG_PWM:       prdata = {24'd0, cfg_reg.pwm_speed};
            REG_EXT:       prdata = {31'd0, cfg_reg.counter_external};
            REG_POLARITY:  prdata = {31'd0, cfg_reg.polarity_inverted};
            REG_OUTLEVELS: prdata = {30'd0, cfg_reg.output_levels};
            REG_SENSLOW:   prdata = {30'd0, cfg_reg.sensor_active_low};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/tss_core.sv -----
// Step state machine: sequencer state register and one-item update logic.
module tss_core import tss_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  step_en,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    state_t                state_reg;
    state_t                state_next;
    logic                  busy;
    logic                  locked;
    logic                  counted;
    logic                  moved;
    logic                  arrived;
    logic                  dir_high;
    logic [TIMER_BITS-1:0] el;
    logic [CMP_W-1:0]      el_cmp;
    logic                  acc;
    logic [1:0]            rd_res;
    logic                  rd_edge;

    assign busy = (state_reg.phase == PH_SETTLE) || (state_reg.phase == PH_PULSE)
               || (state_reg.phase == PH_MOVE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase          <= PH_STOP;
            state_reg.elapsed        <= '0;
            state_reg.movement_seen  <= 1'b0;
            state_reg.pending_result <= RES_NONE;
            state_reg.turn_direction <= 1'b0;
            state_reg.motor_on       <= 1'b0;
            state_reg.unlock_on      <= 1'b0;
            state_reg.lamp_on        <= 1'b1;
            state_reg.prev_lock      <= 1'b0;
            state_reg.prev_counter   <= 1'b0;
            state_reg.primed         <= 1'b0;
            state_reg.lock_event     <= 1'b0;
            state_reg.counter_event  <= 1'b0;
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        acc        = 1'b0;
        rd_res     = 2'd0;
        rd_edge    = 1'b0;
        locked     = item.lock_pin ^ cfg.sensor_active_low[0];
        counted    = item.counter_pin ^ cfg.sensor_active_low[1];
        moved      = 1'b0;
        arrived    = 1'b0;
        el         = state_reg.elapsed;
        if (state_reg.elapsed != TIMER_TOP) begin
            el = state_reg.elapsed + 1'b1;
        end
        el_cmp = CMP_W'(el);

        case (item.kind)
            KIND_TICK: begin
                // first tick after reset only samples the pins
                if (state_reg.primed) begin
                    if (locked && !state_reg.prev_lock) state_next.lock_event = 1'b1;
                    if (counted && !state_reg.prev_counter) state_next.counter_event = 1'b1;
                end
                state_next.primed       = 1'b1;
                state_next.prev_lock    = locked;
                state_next.prev_counter = counted;
                state_next.elapsed      = el;

                unique case (state_reg.phase)
                    PH_SETTLE: begin
                        if (el_cmp >= CMP_W'(cfg.settle_ticks)) begin
                            state_next.motor_on  = 1'b1;
                            state_next.unlock_on = 1'b1;
                            state_next.elapsed   = '0;
                            state_next.phase     = PH_PULSE;
                        end
                    end
                    PH_PULSE: begin
                        if (el_cmp >= CMP_W'(cfg.pulse_ticks)) begin
                            state_next.unlock_on     = 1'b0;
                            state_next.elapsed       = '0;
                            state_next.movement_seen = 1'b0;
                            state_next.phase         = PH_MOVE;
                        end
                    end
                    PH_MOVE: begin
                        moved = state_reg.movement_seen || !locked;
                        state_next.movement_seen = moved;
                        if (moved) begin
                            if (cfg.counter_external) begin
                                // edge latched above in this same tick counts too
                                arrived = state_next.counter_event;
                                state_next.counter_event = 1'b0;
                            end else begin
                                arrived = locked;
                            end
                        end
                        if (arrived) begin
                            state_next.unlock_on      = 1'b0;
                            state_next.lamp_on        = 1'b1;
                            state_next.pending_result = RES_DONE;
                            state_next.phase          = PH_STOP;
                        end else if (el_cmp >= CMP_W'(cfg.timeout_ticks)) begin
                            state_next.motor_on       = 1'b0;
                            state_next.unlock_on      = 1'b0;
                            state_next.lamp_on        = 1'b1;
                            state_next.pending_result = RES_TIMEOUT;
                            state_next.phase          = PH_ERR;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_START: begin
                if (!busy) begin
                    state_next.pending_result = RES_NONE;
                    state_next.movement_seen  = 1'b0;
                    state_next.lamp_on        = 1'b0;
                    state_next.turn_direction = item.direction;
                    state_next.elapsed        = '0;
                    state_next.phase          = PH_SETTLE;
                    acc                       = 1'b1;
                end
            end
            KIND_STOP: begin
                state_next.motor_on  = 1'b0;
                state_next.unlock_on = 1'b0;
                state_next.lamp_on   = 1'b1;
                if (busy) state_next.pending_result = RES_CANCEL;
                state_next.phase     = PH_STOP;
            end
            default: begin
                rd_res                    = state_reg.pending_result;
                state_next.pending_result = RES_NONE;
                rd_edge                   = state_reg.lock_event;
                state_next.lock_event     = 1'b0;
            end
        endcase
    end

    // result shows the state after the item
    assign dir_high = state_next.turn_direction ^ cfg.output_levels[1];

    always_comb begin
        res.motor_duty      = state_next.motor_on ? cfg.pwm_speed : 8'd0;
        res.direction_relay = ~(dir_high ^ cfg.output_levels[0]);
        res.unlock_relay    = ~(state_next.unlock_on ^ cfg.output_levels[0]);
        res.polarity_relay  = ~(cfg.polarity_inverted ^ cfg.output_levels[0]);
        res.arrived_lamp    = state_next.lamp_on;
        res.phase_code      = state_next.phase;
        res.busy_res        = (state_next.phase == PH_SETTLE)
                           || (state_next.phase == PH_PULSE)
                           || (state_next.phase == PH_MOVE);
        res.accepted        = acc;
        res.step_result     = rd_res;
        res.lock_edge_seen  = rd_edge;
    end

endmodule

// ----- rtl/turntable_step_sequencer.sv -----
// Top level of the turntable step sequencer.
// Usage:
//   Items enter on the s_ channel (valid/ready): kind selects a 1 ms tick
//   (with sampled lock and counter pins), a start step (with direction),
//   a stop, or a read of the pending step result.
//   Every item yields exactly one result on the m_ channel: relay pin
//   levels, motor duty, lamp, phase and busy flag after the item, plus
//   accepted (start), step_result and lock_edge_seen (read).
//   Path: the input register takes the item and feeds the step logic,
//   whose result is caught by the result register.
//   Throughput: one item per cycle while the receiver takes results; the
//   step logic between the two registers is a single pass, so it sets no
//   limit. When the receiver stalls, the result register holds; if the
//   input register is empty, one more item is taken in, then s_ready drops.
//   Reset (aresetn low, synchronous) empties both registers, stops the
//   step with the lamp on, and loads the register defaults. The first tick
//   after reset only samples the sensor pins.
//   The APB port (pready always high) writes the eight registers at
//   byte addresses 0x00..0x1C; write them only while the block is idle.
module turntable_step_sequencer import tss_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic        s_direction,
    input  logic        s_lock_pin,
    input  logic        s_counter_pin,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_motor_duty,
    output logic        m_direction_relay,
    output logic        m_unlock_relay,
    output logic        m_polarity_relay,
    output logic        m_arrived_lamp,
    output logic [2:0]  m_phase_code,
    output logic        m_busy_res,
    output logic        m_accepted,
    output logic [1:0]  m_step_result,
    output logic        m_lock_edge_seen
);

    cfg_t  cfg;
    item_t in_item_reg;
    logic  in_valid_reg;
    res_t  out_res_reg;
    logic  out_valid_reg;
    res_t  step_res;
    logic  advance;

    tss_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // result register free or being emptied this cycle
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg.kind        <= kind_t'(s_kind);
            in_item_reg.direction   <= s_direction;
            in_item_reg.lock_pin    <= s_lock_pin;
            in_item_reg.counter_pin <= s_counter_pin;
        end
    end

    tss_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (in_valid_reg && advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_res_reg <= step_res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_motor_duty      = out_res_reg.motor_duty;
    assign m_direction_relay = out_res_reg.direction_relay;
    assign m_unlock_relay    = out_res_reg.unlock_relay;
    assign m_polarity_relay  = out_res_reg.polarity_relay;
    assign m_arrived_lamp    = out_res_reg.arrived_lamp;
    assign m_phase_code      = out_res_reg.phase_code;
    assign m_busy_res        = out_res_reg.busy_res;
    assign m_accepted        = out_res_reg.accepted;
    assign m_step_result     = out_res_reg.step_result;
    assign m_lock_edge_seen  = out_res_reg.lock_edge_seen;

endmodule

// ----- rtl/tss_checker.sv -----
// Port-level checker for the turntable step sequencer, bound to the top level.
`include "assert_macros.svh"

module tss_checker import tss_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_arrived_lamp,
    input logic [2:0] m_phase_code,
    input logic       m_busy_res,
    input logic       m_accepted,
    input logic [1:0] m_step_result
);

    // lamp is lit exactly when no step is running
    `TSS_ASSERT(a_lamp_vs_busy, aclk, aresetn, m_valid |-> (m_arrived_lamp != m_busy_res), "lamp and busy disagree")

    // a taken start always leaves the block settling
    `TSS_ASSERT(a_accept_settle, aclk, aresetn, (m_valid && m_accepted) |-> (m_busy_res && (m_phase_code == PH_SETTLE)), "accepted start not settling")

    // a step outcome can only be pending once the step has ended
    `TSS_ASSERT(a_result_idle, aclk, aresetn, (m_valid && (m_step_result != RES_NONE)) |-> !m_busy_res, "step result read while busy")

    // a stalled result stays put
    `TSS_ASSERT(a_hold_stall, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_phase_code) && $stable(m_step_result)), "stalled result changed")

    `TSS_ASSERT_RST(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind turntable_step_sequencer tss_checker u_tss_checker (.*);
